/* sv/rrspf_pkg.sv */
// Shared constants, codes and types for the radius/role/spacing point filter.
package rrspf_pkg;

  localparam int MAX_KEPT_DEF   = 64;
  localparam int COORD_BITS_DEF = 21;

  localparam int SQ_W       = 44;
  localparam int CFG_DATA_W = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int LIMIT_W    = 7;
  localparam int ROLE_W     = 4;
  localparam int MASK_W     = 16;
  localparam int VERDICT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROLE_MASK   = 3'd6;

  localparam logic [VERDICT_W-1:0] VERDICT_KEPT      = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_RADIUS    = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_ROLE      = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_CLOSE = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_LIMIT     = 3'd4;

  localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_SWEEP,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic shift;
    logic wrap;
    logic load;
  } cell_ctl_t;

endpackage

/* sv/rrspf_cell.sv */
// One cell of the kept-point ring: holds one point and passes it on when the ring turns.
module rrspf_cell import rrspf_pkg::*; #(
  parameter int PT_W = 3 * COORD_BITS_DEF
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [PT_W-1:0] head,
  input  logic [PT_W-1:0] next_pt,
  input  logic [PT_W-1:0] load_pt,
  output logic [PT_W-1:0] pt
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pt <= load_pt;
    end else if (ctl.shift) begin
      // last live cell takes the head so the ring closes at the fill level
      pt <= ctl.wrap ? head : next_pt;
    end
  end

endmodule

/* sv/rrspf_dist.sv */
// Two-stage squared-distance unit with radius and spacing compares.
module rrspf_dist import rrspf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic                    tag_in,
  input  logic [3*COORD_BITS-1:0] a,
  input  logic [3*COORD_BITS-1:0] b,
  input  logic [SQ_W-1:0]         radius_sq,
  input  logic [SQ_W-1:0]         spacing_sq,
  output logic                    done,
  output logic                    tag_out,
  output logic                    far,
  output logic                    close
);

  localparam int DW    = COORD_BITS + 1;
  localparam int SQ2_W = 2 * DW;
  localparam int SUM_W = SQ2_W + 2;
  localparam int CMP_W = (SUM_W > SQ_W) ? SUM_W : SQ_W;

  logic signed [DW-1:0]    diff [3];
  logic signed [SQ2_W-1:0] prod [3];
  logic        [SQ2_W-1:0] sq   [3];
  logic                    s1_valid;
  logic                    s1_tag;
  logic        [SUM_W-1:0] sum;
  logic        [CMP_W-1:0] sum_ext;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({a[k*COORD_BITS+COORD_BITS-1], a[k*COORD_BITS +: COORD_BITS]})
              - $signed({b[k*COORD_BITS+COORD_BITS-1], b[k*COORD_BITS +: COORD_BITS]});
      prod[k] = diff[k] * diff[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq[k] <= $unsigned(prod[k]);
    end
  end

  assign sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
  assign sum_ext = CMP_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= go;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag  <= tag_in;
    tag_out <= s1_tag;
    far     <= sum_ext > CMP_W'(radius_sq);
    close   <= sum_ext < CMP_W'(spacing_sq);
  end

endmodule

/* sv/radius_role_spacing_point_filter.sv */
// Point filter top level: config registers, sequencer, kept-point ring and distance unit.
// Each candidate word is tested against the search radius and role mask, then against
// every point kept in the current scan. Kept points sit in a ring of cells that turns
// once per candidate, feeding one stored point per cycle to a single two-stage distance
// unit. The next candidate is taken only once the block is back in idle, after the
// result of the last one has been loaded into the output register. The result
// sits in an output register; the next candidate is taken while it waits. Configuration
// writes are taken in every cycle and must only be made while the block is idle.
module radius_role_spacing_point_filter import rrspf_pkg::*; #(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [ROLE_W-1:0]            role,
  input  logic                         new_scan,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic [VERDICT_W-1:0]         verdict,
  output logic [LIMIT_W-1:0]           kept_count
);

  localparam int PT_W  = 3 * COORD_BITS;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // configuration
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic [SQ_W-1:0]              search_radius_sq;
  logic [SQ_W-1:0]              min_spacing_sq;
  logic [LIMIT_W-1:0]           keep_limit;
  logic [MASK_W-1:0]            role_mask;

  // sequencer
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  total_m1;
  logic [CNT_W-1:0]  total_new;
  logic [CNT_W-1:0]  sweep_cnt;
  logic              drain_cnt;
  logic              far_flag;
  logic              close_flag;
  logic              sweep_shift;
  logic              out_load;
  logic              load_en;

  // candidate
  logic [PT_W-1:0]   cand_pt;
  logic [ROLE_W-1:0] cand_role;

  // decision
  logic [LIM_W-1:0]     limit_eff;
  logic [LIM_W-1:0]     total_new_ext;
  logic [VERDICT_W-1:0] verdict_d;
  logic                 kept_d;

  // ring and distance unit
  logic [PT_W-1:0] cell_pt  [MAX_KEPT];
  logic [PT_W-1:0] next_pt  [MAX_KEPT];
  cell_ctl_t       cell_ctl [MAX_KEPT];
  logic [PT_W-1:0] origin_pt;
  logic [PT_W-1:0] dist_b;
  logic            dist_go;
  logic            dist_done;
  logic            dist_tag;
  logic            dist_far;
  logic            dist_close;

  assign cfg_ready = 1'b1;
  assign origin_pt = {origin_z, origin_y, origin_x};
  assign total_m1  = total - CNT_W'(1);

  genvar i;
  generate
    for (i = 0; i < MAX_KEPT; i++) begin : g_cell
      if (i == MAX_KEPT - 1) begin : g_tail
        assign next_pt[i] = cell_pt[0];
      end else begin : g_body
        assign next_pt[i] = cell_pt[i+1];
      end
      assign cell_ctl[i].shift = sweep_shift;
      assign cell_ctl[i].wrap  = (total_m1 == CNT_W'(i));
      assign cell_ctl[i].load  = load_en && (total == CNT_W'(i));

      rrspf_cell #(
        .PT_W(PT_W)
      ) u_cell (
        .clk    (clk),
        .ctl    (cell_ctl[i]),
        .head   (cell_pt[0]),
        .next_pt(next_pt[i]),
        .load_pt(cand_pt),
        .pt     (cell_pt[i])
      );
    end
  endgenerate

  assign dist_go = (state == ST_ORIGIN) || (state == ST_SWEEP);
  assign dist_b  = (state == ST_ORIGIN) ? origin_pt : cell_pt[0];

  rrspf_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .go        (dist_go),
    .tag_in    (state == ST_ORIGIN),
    .a         (cand_pt),
    .b         (dist_b),
    .radius_sq (search_radius_sq),
    .spacing_sq(min_spacing_sq),
    .done      (dist_done),
    .tag_out   (dist_tag),
    .far       (dist_far),
    .close     (dist_close)
  );

  // verdict: radius, then role, then limit, then spacing
  always_comb begin
    limit_eff = LIM_W'(keep_limit);
    if (keep_limit == '0) begin
      limit_eff = LIM_W'(1);
    end
    if (limit_eff > LIM_W'(MAX_KEPT)) begin
      limit_eff = LIM_W'(MAX_KEPT);
    end
    if (far_flag) begin
      verdict_d = VERDICT_RADIUS;
    end else if (!role_mask[cand_role]) begin
      verdict_d = VERDICT_ROLE;
    end else if (LIM_W'(total) >= limit_eff) begin
      verdict_d = VERDICT_LIMIT;
    end else if (close_flag) begin
      verdict_d = VERDICT_TOO_CLOSE;
    end else begin
      verdict_d = VERDICT_KEPT;
    end
    kept_d        = (verdict_d == VERDICT_KEPT);
    total_new     = total + CNT_W'(kept_d);
    total_new_ext = LIM_W'(total_new);
  end

  assign load_en = out_load && kept_d;

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    sweep_shift = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_ORIGIN;
        end
      end
      ST_ORIGIN: begin
        state_next = (total == '0) ? ST_DRAIN : ST_SWEEP;
      end
      ST_SWEEP: begin
        sweep_shift = 1'b1;
        if (sweep_cnt == total_m1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      total            <= '0;
      sweep_cnt        <= '0;
      drain_cnt        <= 1'b0;
      far_flag         <= 1'b0;
      close_flag       <= 1'b0;
      out_valid        <= 1'b0;
      origin_x         <= '0;
      origin_y         <= '0;
      origin_z         <= '0;
      search_radius_sq <= '0;
      min_spacing_sq   <= '0;
      keep_limit       <= KEEP_LIMIT_RST;
      role_mask        <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_ORIGIN_X:   origin_x         <= cfg_data[COORD_BITS-1:0];
          REG_ORIGIN_Y:   origin_y         <= cfg_data[COORD_BITS-1:0];
          REG_ORIGIN_Z:   origin_z         <= cfg_data[COORD_BITS-1:0];
          REG_RADIUS_SQ:  search_radius_sq <= cfg_data[SQ_W-1:0];
          REG_SPACING_SQ: min_spacing_sq   <= cfg_data[SQ_W-1:0];
          REG_KEEP_LIMIT: keep_limit       <= cfg_data[LIMIT_W-1:0];
          REG_ROLE_MASK:  role_mask        <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        close_flag <= 1'b0;
        if (new_scan) begin
          total <= '0;
        end
      end

      if (state == ST_ORIGIN) begin
        sweep_cnt <= '0;
      end else if (sweep_shift) begin
        sweep_cnt <= sweep_cnt + CNT_W'(1);
      end

      drain_cnt <= (state == ST_DRAIN) && !drain_cnt;

      if (dist_done) begin
        if (dist_tag) begin
          far_flag <= dist_far;
        end else if (dist_close) begin
          close_flag <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
        total     <= total_new;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand_pt   <= {pos_z, pos_y, pos_x};
      cand_role <= role;
    end
    if (out_load) begin
      accepted   <= kept_d;
      verdict    <= verdict_d;
      kept_count <= total_new_ext[LIMIT_W-1:0];
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(total) <= LIM_W'(MAX_KEPT))
    else $error("kept total beyond table depth");

  a_accept_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (verdict == VERDICT_KEPT)))
    else $error("accepted flag disagrees with verdict");

  a_no_stray_distance: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("distance result outside a sweep");

  a_decide_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == ST_IDLE && out_valid))
    else $error("result word not presented after decision");

endmodule
